// ===== rtl/oetb_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package oetb_pkg;

  localparam int NUM_TIMERS_DEF   = 16;
  localparam int MAX_EXPIRIES_DEF = 16;
  localparam int TIME_W           = 48;
  localparam int DUR_W            = 32;
  localparam int SLOT_W           = 4;

  // item modes
  localparam logic [2:0] MODE_POLL   = 3'd0;
  localparam logic [2:0] MODE_START  = 3'd1;
  localparam logic [2:0] MODE_STOP   = 3'd2;
  localparam logic [2:0] MODE_FFWD   = 3'd3;
  localparam logic [2:0] MODE_PAUSE  = 3'd4;
  localparam logic [2:0] MODE_RESUME = 3'd5;

  // result kinds
  localparam logic KIND_ACK    = 1'b0;
  localparam logic KIND_EXPIRY = 1'b1;

  // timer store write controls
  typedef struct packed {
    logic et_we;
    logic per_we;
    logic run_set;
    logic run_clr;
    logic one_shot;
  } store_ctl_t;

endpackage
`default_nettype wire

// ===== rtl/ordered_expiry_timer_bank_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Timer bank of NUM_TIMERS one-shot or periodic timers on a virtual millisecond
// clock. Assert start with an item while busy is low; busy stays high until the
// item's last result has been shown. Results appear one per out_valid pulse and
// cannot be stalled, so the receiver must take every pulse; out_last marks the
// final result of an item. An item that expires nothing gives one acknowledge.
// Every time sum goes through one shared 49-bit adder, one step a cycle: an
// item other than a poll or fast forward passes two virtual-time steps and, for
// a start or a resume, its own update steps before its result, and the next item
// can be accepted in the result cycle. A poll scans all slots with one comparator
// fed from a memory read port and scans again after each expiry found, up to
// MAX_EXPIRIES expiries; a fast forward first adds its advance, then scans the
// same way.
module ordered_expiry_timer_bank_unit #(
  parameter int NUM_TIMERS   = oetb_pkg::NUM_TIMERS_DEF,
  parameter int MAX_EXPIRIES = oetb_pkg::MAX_EXPIRIES_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [2:0]                    in_mode,
  input  wire logic [oetb_pkg::TIME_W-1:0]   in_raw_time,
  input  wire logic [oetb_pkg::SLOT_W-1:0]   in_slot,
  input  wire logic [oetb_pkg::DUR_W-1:0]    in_duration,
  input  wire logic                          in_one_shot,
  input  wire logic [oetb_pkg::DUR_W-1:0]    in_advance,
  output logic                               out_valid,
  output logic                               out_kind,
  output logic [oetb_pkg::SLOT_W-1:0]        out_expired_slot,
  output logic [oetb_pkg::TIME_W-1:0]        out_expire_time,
  output logic                               out_last
);

  localparam int IW = $clog2(NUM_TIMERS);
  localparam int CW = IW + 1;
  localparam int NW = $clog2(MAX_EXPIRIES + 1);
  localparam int TW = oetb_pkg::TIME_W;
  localparam int DW = oetb_pkg::DUR_W;
  localparam logic [CW-1:0] SCAN_END = CW'(NUM_TIMERS);
  localparam logic [NW-1:0] N_LAST   = NW'(MAX_EXPIRIES - 1);

  typedef enum logic [9:0] {
    ST_IDLE = 10'b0000000001,
    ST_FWD  = 10'b0000000010,
    ST_VT1  = 10'b0000000100,
    ST_VT2  = 10'b0000001000,
    ST_ACT  = 10'b0000010000,
    ST_RES1 = 10'b0000100000,
    ST_RES2 = 10'b0001000000,
    ST_SCAN = 10'b0010000000,
    ST_PER  = 10'b0100000000,
    ST_UPD  = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;

  // latched item
  logic [2:0]    mode_r;
  logic [TW-1:0] raw_r;
  logic [oetb_pkg::SLOT_W-1:0] slot_r;
  logic [DW-1:0] dur_r;
  logic          os_in_r;
  logic [DW-1:0] adv_r;

  // time state
  logic [TW-1:0] fwd_r, fwd_nxt;
  logic [TW:0]   po_r, po_nxt;
  logic          paused_r, paused_nxt;
  logic [TW-1:0] paused_at_r, paused_at_nxt;
  logic [TW-1:0] acc_r, acc_nxt;
  logic [TW-1:0] now_r, now_nxt;

  // scan state
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          dv_r, dv_nxt;
  logic [IW-1:0] didx_r, didx_nxt;
  logic          found_r, found_nxt;
  logic [IW-1:0] best_idx_r, best_idx_nxt;
  logic [TW-1:0] best_et_r, best_et_nxt;
  logic [NW-1:0] n_r, n_nxt;
  logic          pend_r, pend_nxt;
  logic [IW-1:0] pend_idx_r, pend_idx_nxt;
  logic [TW-1:0] pend_et_r, pend_et_nxt;

  // result registers
  logic          ov_r, ov_nxt;
  logic          ok_r, ok_nxt;
  logic [oetb_pkg::SLOT_W-1:0] os_slot_r, os_slot_nxt;
  logic [TW-1:0] ot_r, ot_nxt;
  logic          ol_r, ol_nxt;

  // shared adder
  logic [TW:0] add_a, add_b, add_sum;
  logic        add_ci;

  // store port
  oetb_pkg::store_ctl_t ctl;
  logic [IW-1:0] wr_idx, rd_idx;
  logic [TW-1:0] wr_et, rd_et;
  logic [DW-1:0] rd_per;
  logic          rd_run, rd_one_shot;

  logic slot_ok;
  logic cand;

  assign slot_ok = (32'(slot_r) < NUM_TIMERS);

  assign add_sum = add_a + add_b + {{TW{1'b0}}, add_ci};

  assign cand = dv_r && rd_run && (now_r >= rd_et) && (!found_r || (rd_et < best_et_r));

  oetb_store #(.NUM_TIMERS(NUM_TIMERS)) u_store (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (ctl),
    .wr_idx      (wr_idx),
    .wr_et       (wr_et),
    .wr_per      (dur_r),
    .rd_idx      (rd_idx),
    .per_idx     (best_idx_r),
    .rd_et       (rd_et),
    .rd_run      (rd_run),
    .rd_per      (rd_per),
    .rd_one_shot (rd_one_shot)
  );

  // pick adder operands by step
  always_comb begin
    add_a  = '0;
    add_b  = '0;
    add_ci = 1'b0;
    case (state_r)
      ST_FWD: begin
        add_a = {1'b0, fwd_r};
        add_b = (TW + 1)'(adv_r);
      end
      ST_VT1: begin
        add_a = {1'b0, paused_r ? paused_at_r : raw_r};
        add_b = {1'b0, fwd_r};
      end
      ST_VT2: begin
        add_a = {1'b0, acc_r};
        add_b = {1'b0, po_r[TW-1:0]};
      end
      ST_ACT: begin
        add_a = {1'b0, now_r};
        add_b = (TW + 1)'(dur_r);
      end
      ST_RES1: begin
        add_a = po_r;
        add_b = {1'b0, paused_at_r};
      end
      ST_RES2: begin
        add_a  = po_r;
        add_b  = ~{1'b0, raw_r};
        add_ci = 1'b1;
      end
      ST_UPD: begin
        add_a = {1'b0, best_et_r};
        add_b = (TW + 1)'(rd_per);
      end
      default: begin
      end
    endcase
  end

  // sequence the item
  always_comb begin
    state_nxt     = state_r;
    fwd_nxt       = fwd_r;
    po_nxt        = po_r;
    paused_nxt    = paused_r;
    paused_at_nxt = paused_at_r;
    acc_nxt       = acc_r;
    now_nxt       = now_r;
    cnt_nxt       = cnt_r;
    dv_nxt        = 1'b0;
    didx_nxt      = didx_r;
    found_nxt     = found_r;
    best_idx_nxt  = best_idx_r;
    best_et_nxt   = best_et_r;
    n_nxt         = n_r;
    pend_nxt      = pend_r;
    pend_idx_nxt  = pend_idx_r;
    pend_et_nxt   = pend_et_r;
    ov_nxt        = 1'b0;
    ok_nxt        = ok_r;
    os_slot_nxt   = os_slot_r;
    ot_nxt        = ot_r;
    ol_nxt        = ol_r;
    ctl           = '0;
    wr_idx        = IW'(slot_r);
    wr_et         = add_sum[TW-1:0];
    rd_idx        = cnt_r[IW-1:0];

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = (in_mode == oetb_pkg::MODE_FFWD) ? ST_FWD : ST_VT1;
        end
      end
      ST_FWD: begin
        fwd_nxt   = add_sum[TW-1:0];
        state_nxt = ST_VT1;
      end
      ST_VT1: begin
        acc_nxt   = add_sum[TW-1:0];
        state_nxt = ST_VT2;
      end
      ST_VT2: begin
        now_nxt = add_sum[TW-1:0];
        // default: acknowledge with the virtual time
        ok_nxt      = oetb_pkg::KIND_ACK;
        os_slot_nxt = '0;
        ot_nxt      = add_sum[TW-1:0];
        ol_nxt      = 1'b1;
        case (mode_r)
          oetb_pkg::MODE_POLL, oetb_pkg::MODE_FFWD: begin
            cnt_nxt   = '0;
            found_nxt = 1'b0;
            n_nxt     = '0;
            pend_nxt  = 1'b0;
            state_nxt = ST_SCAN;
          end
          oetb_pkg::MODE_START: begin
            state_nxt = slot_ok ? ST_ACT : ST_IDLE;
            ov_nxt    = !slot_ok;
          end
          oetb_pkg::MODE_STOP: begin
            ctl.run_clr = slot_ok;
            ov_nxt      = 1'b1;
            state_nxt   = ST_IDLE;
          end
          oetb_pkg::MODE_PAUSE: begin
            if (!paused_r) begin
              paused_nxt    = 1'b1;
              paused_at_nxt = raw_r;
            end
            ov_nxt    = 1'b1;
            state_nxt = ST_IDLE;
          end
          oetb_pkg::MODE_RESUME: begin
            state_nxt = paused_r ? ST_RES1 : ST_IDLE;
            ov_nxt    = !paused_r;
          end
          default: begin
            ov_nxt    = 1'b1;
            state_nxt = ST_IDLE;
          end
        endcase
      end
      ST_ACT: begin
        ctl.et_we    = 1'b1;
        ctl.per_we   = 1'b1;
        ctl.run_set  = 1'b1;
        ctl.one_shot = os_in_r;
        ov_nxt       = 1'b1;
        state_nxt    = ST_IDLE;
      end
      ST_RES1: begin
        po_nxt    = add_sum;
        state_nxt = ST_RES2;
      end
      ST_RES2: begin
        po_nxt     = add_sum;
        paused_nxt = 1'b0;
        ov_nxt     = 1'b1;
        state_nxt  = ST_IDLE;
      end
      ST_SCAN: begin
        // issue reads, then compare the returned entry
        if (cnt_r != SCAN_END) begin
          dv_nxt   = 1'b1;
          didx_nxt = cnt_r[IW-1:0];
          cnt_nxt  = cnt_r + 1'b1;
        end
        if (cand) begin
          found_nxt    = 1'b1;
          best_idx_nxt = didx_r;
          best_et_nxt  = rd_et;
        end
        if (cnt_r == SCAN_END && !dv_r) begin
          if (pend_r) begin
            ov_nxt      = 1'b1;
            ok_nxt      = oetb_pkg::KIND_EXPIRY;
            os_slot_nxt = oetb_pkg::SLOT_W'(pend_idx_r);
            ot_nxt      = pend_et_r;
            ol_nxt      = !found_r;
          end else if (!found_r) begin
            ov_nxt = 1'b1;
          end
          state_nxt = found_r ? ST_PER : ST_IDLE;
        end
      end
      ST_PER: begin
        state_nxt = ST_UPD;
      end
      ST_UPD: begin
        wr_idx = best_idx_r;
        if (rd_one_shot) begin
          ctl.run_clr = 1'b1;
        end else begin
          ctl.et_we = 1'b1;
        end
        if (n_r == N_LAST) begin
          ov_nxt      = 1'b1;
          ok_nxt      = oetb_pkg::KIND_EXPIRY;
          os_slot_nxt = oetb_pkg::SLOT_W'(best_idx_r);
          ot_nxt      = best_et_r;
          ol_nxt      = 1'b1;
          state_nxt   = ST_IDLE;
        end else begin
          n_nxt        = n_r + 1'b1;
          pend_nxt     = 1'b1;
          pend_idx_nxt = best_idx_r;
          pend_et_nxt  = best_et_r;
          cnt_nxt      = '0;
          found_nxt    = 1'b0;
          state_nxt    = ST_SCAN;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // latch the item on accept
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && start) begin
      mode_r  <= in_mode;
      raw_r   <= in_raw_time;
      slot_r  <= in_slot;
      dur_r   <= in_duration;
      os_in_r <= in_one_shot;
      adv_r   <= in_advance;
    end
  end

  // advance payload registers
  always_ff @(posedge clk) begin
    acc_r      <= acc_nxt;
    now_r      <= now_nxt;
    cnt_r      <= cnt_nxt;
    didx_r     <= didx_nxt;
    best_idx_r <= best_idx_nxt;
    best_et_r  <= best_et_nxt;
    n_r        <= n_nxt;
    pend_idx_r <= pend_idx_nxt;
    pend_et_r  <= pend_et_nxt;
    ok_r       <= ok_nxt;
    os_slot_r  <= os_slot_nxt;
    ot_r       <= ot_nxt;
    ol_r       <= ol_nxt;
  end

  // advance control and time state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fwd_r       <= '0;
      po_r        <= '0;
      paused_r    <= 1'b0;
      paused_at_r <= '0;
      dv_r        <= 1'b0;
      found_r     <= 1'b0;
      pend_r      <= 1'b0;
      ov_r        <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fwd_r       <= fwd_nxt;
      po_r        <= po_nxt;
      paused_r    <= paused_nxt;
      paused_at_r <= paused_at_nxt;
      dv_r        <= dv_nxt;
      found_r     <= found_nxt;
      pend_r      <= pend_nxt;
      ov_r        <= ov_nxt;
    end
  end

  assign busy             = (state_r != ST_IDLE);
  assign out_valid        = ov_r;
  assign out_kind         = ok_r;
  assign out_expired_slot = os_slot_r;
  assign out_expire_time  = ot_r;
  assign out_last         = ol_r;

`ifndef NO_ASSERTIONS
  a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> !busy) else $error("busy after last result");
  a_mid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> busy) else $error("idle before last result");
  a_ack_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == oetb_pkg::KIND_ACK |-> out_last)
    else $error("acknowledge not last");
  a_take: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("item not taken");
`endif

endmodule
`default_nettype wire

// ===== rtl/oetb_store.sv =====
`timescale 1ns / 1ps
`default_nettype none
module oetb_store #(
  parameter int NUM_TIMERS = oetb_pkg::NUM_TIMERS_DEF,
  localparam int IW = $clog2(NUM_TIMERS)
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire oetb_pkg::store_ctl_t         ctl,
  input  wire logic [IW-1:0]                wr_idx,
  input  wire logic [oetb_pkg::TIME_W-1:0]  wr_et,
  input  wire logic [oetb_pkg::DUR_W-1:0]   wr_per,
  input  wire logic [IW-1:0]                rd_idx,
  input  wire logic [IW-1:0]                per_idx,
  output logic [oetb_pkg::TIME_W-1:0]       rd_et,
  output logic                              rd_run,
  output logic [oetb_pkg::DUR_W-1:0]        rd_per,
  output logic                              rd_one_shot
);

  logic [oetb_pkg::TIME_W-1:0] et_mem [NUM_TIMERS];
  logic [oetb_pkg::DUR_W-1:0]  per_mem [NUM_TIMERS];
  logic [NUM_TIMERS-1:0]       run_r;
  logic [NUM_TIMERS-1:0]       os_r;

  // write expire times and periods
  always_ff @(posedge clk) begin
    if (ctl.et_we) begin
      et_mem[wr_idx] <= wr_et;
    end
    if (ctl.per_we) begin
      per_mem[wr_idx] <= wr_per;
    end
  end

  // registered reads
  always_ff @(posedge clk) begin
    rd_et       <= et_mem[rd_idx];
    rd_run      <= run_r[rd_idx];
    rd_per      <= per_mem[per_idx];
    rd_one_shot <= os_r[per_idx];
  end

  // hold running and one-shot flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= '0;
      os_r  <= '0;
    end else begin
      if (ctl.run_set) begin
        run_r[wr_idx] <= 1'b1;
        os_r[wr_idx]  <= ctl.one_shot;
      end else if (ctl.run_clr) begin
        run_r[wr_idx] <= 1'b0;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_no_set_clr: assert property (@(posedge clk) disable iff (!rst_n)
    !(ctl.run_set && ctl.run_clr)) else $error("set and clear together");
  a_set_takes: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.run_set |=> run_r[$past(wr_idx)]) else $error("run flag not set");
  a_clr_takes: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.run_clr && !ctl.run_set |=> !run_r[$past(wr_idx)])
    else $error("run flag not cleared");
`endif

endmodule
`default_nettype wire

// ===== verif/timer_bank_checker.sv =====
`timescale 1ns / 1ps
module timer_bank_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic        busy,
  input  wire logic [2:0]  in_mode,
  input  wire logic [47:0] in_raw_time,
  input  wire logic [3:0]  in_slot,
  input  wire logic [31:0] in_duration,
  input  wire logic        in_one_shot,
  input  wire logic [31:0] in_advance,
  input  wire logic        out_valid,
  input  wire logic        out_kind,
  input  wire logic [3:0]  out_expired_slot,
  input  wire logic [47:0] out_expire_time,
  input  wire logic        out_last,
  output int               fail_count,
  output int               expiry_count,
  output int               pending_count
);

  typedef struct packed {
    logic        kind;
    logic [3:0]  slot;
    logic [47:0] when;
    logic        last;
  } timer_event_t;

  // timer bank shadow
  logic [47:0] exp_at [16];
  logic [31:0] period [16];
  logic        running [16];
  logic        single [16];
  logic [47:0] fwd_ofs;
  logic [48:0] pause_ofs;
  logic        is_paused;
  logic [47:0] paused_raw;

  timer_event_t event_q[$];

  assign pending_count = event_q.size();

  function automatic logic [47:0] vnow(input logic [47:0] raw);
    logic [48:0] s;
    s = {1'b0, is_paused ? paused_raw : raw} + {1'b0, fwd_ofs} + pause_ofs;
    return s[47:0];
  endfunction

  // drain expired timers, earliest first, lowest slot on ties
  function automatic int drain_expired(input logic [47:0] now);
    int n;
    int best;
    timer_event_t e;
    n = 0;
    while (n < oetb_pkg::MAX_EXPIRIES_DEF) begin
      best = -1;
      for (int i = 0; i < 16; i++)
        if (running[i] && now >= exp_at[i])
          if (best < 0 || exp_at[best] > exp_at[i]) best = i;
      if (best < 0) break;
      e.kind = oetb_pkg::KIND_EXPIRY;
      e.slot = best[3:0];
      e.when = exp_at[best];
      e.last = 1'b0;
      event_q = {event_q, e};
      n++;
      if (single[best]) running[best] = 1'b0;
      else exp_at[best] = exp_at[best] + {16'd0, period[best]};
    end
    if (n > 0) event_q[event_q.size() - 1].last = 1'b1;
    return n;
  endfunction

  task automatic predict_item();
    int n;
    timer_event_t e;
    n = 0;
    case (in_mode)
      oetb_pkg::MODE_POLL: n = drain_expired(vnow(in_raw_time));
      oetb_pkg::MODE_START: begin
        exp_at[in_slot]  = vnow(in_raw_time) + {16'd0, in_duration};
        period[in_slot]  = in_duration;
        single[in_slot]  = in_one_shot;
        running[in_slot] = 1'b1;
      end
      oetb_pkg::MODE_STOP: running[in_slot] = 1'b0;
      oetb_pkg::MODE_FFWD: begin
        fwd_ofs = fwd_ofs + {16'd0, in_advance};
        n = drain_expired(vnow(in_raw_time));
      end
      oetb_pkg::MODE_PAUSE: if (!is_paused) begin
        paused_raw = in_raw_time;
        is_paused  = 1'b1;
      end
      oetb_pkg::MODE_RESUME: if (is_paused) begin
        is_paused = 1'b0;
        pause_ofs = pause_ofs + {1'b0, paused_raw} - {1'b0, in_raw_time};
      end
      default: ;
    endcase
    if (n == 0) begin
      e.kind = oetb_pkg::KIND_ACK;
      e.slot = '0;
      e.when = vnow(in_raw_time);
      e.last = 1'b1;
      event_q = {event_q, e};
    end
  endtask

  task automatic report(input string what, input logic [47:0] got, input logic [47:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  // check results, then predict the accepted item
  always @(posedge clk) begin
    timer_event_t e;
    if (!rst_n) begin
      for (int i = 0; i < 16; i++) begin
        exp_at[i] = '0; period[i] = '0; running[i] = 1'b0; single[i] = 1'b0;
      end
      fwd_ofs = '0; pause_ofs = '0; is_paused = 1'b0; paused_raw = '0;
      event_q.delete();
      fail_count = 0;
      expiry_count = 0;
    end else begin
      if (out_valid) begin
        if (event_q.size() == 0) begin
          report("unexpected result", {47'd0, out_kind}, '0);
        end else begin
          e = event_q.pop_front();
          if (out_kind !== e.kind) report("kind", {47'd0, out_kind}, {47'd0, e.kind});
          if (out_expired_slot !== e.slot)
            report("slot", {44'd0, out_expired_slot}, {44'd0, e.slot});
          if (out_expire_time !== e.when) report("time", out_expire_time, e.when);
          if (out_last !== e.last) report("last", {47'd0, out_last}, {47'd0, e.last});
          if (e.kind == oetb_pkg::KIND_EXPIRY) expiry_count++;
        end
      end
      if (start && !busy) predict_item();
    end
  end
endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
module testbench;

  localparam int IDLE_LIMIT = 20000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic [2:0]  in_mode = oetb_pkg::MODE_POLL;
  logic [47:0] in_raw_time = '0;
  logic [3:0]  in_slot = '0;
  logic [31:0] in_duration = '0;
  logic        in_one_shot = 1'b0;
  logic [31:0] in_advance = '0;
  logic        busy, out_valid, out_kind, out_last;
  logic [3:0]  out_expired_slot;
  logic [47:0] out_expire_time;
  int          fail_count, expiry_count, pending_count;
  int          idle_cycles = 0;
  int          items_sent = 0;
  int          gap_pct = 0;
  logic [47:0] wall = '0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  ordered_expiry_timer_bank_unit i_dut (
    .clk, .rst_n, .start, .busy, .in_mode, .in_raw_time, .in_slot, .in_duration,
    .in_one_shot, .in_advance, .out_valid, .out_kind, .out_expired_slot,
    .out_expire_time, .out_last
  );

  timer_bank_checker i_checker (
    .clk, .rst_n, .start, .busy, .in_mode, .in_raw_time, .in_slot, .in_duration,
    .in_one_shot, .in_advance, .out_valid, .out_kind, .out_expired_slot,
    .out_expire_time, .out_last, .fail_count, .expiry_count, .pending_count
  );

  // watchdog: end the run when no item is accepted and no result shown for too long
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // idle for a random gap, then hold the item until accepted
  task automatic send(input logic [2:0] m, input logic [47:0] raw, input logic [3:0] s,
                      input logic [31:0] d, input logic os, input logic [31:0] adv);
    if (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < gap_pct) @(posedge clk);
    end
    start       <= 1'b1;
    in_mode     <= m;
    in_raw_time <= raw;
    in_slot     <= s;
    in_duration <= d;
    in_one_shot <= os;
    in_advance  <= adv;
    @(posedge clk);
    while (busy) @(posedge clk);
    items_sent++;
  endtask

  // advance wall time mostly in small steps, sometimes jump to a random time
  task automatic random_item();
    int r;
    logic [31:0] d;
    logic [31:0] x;
    logic [31:0] a;
    logic [3:0]  s;
    logic        o;
    r = $urandom_range(99);
    if ($urandom_range(19) == 0) wall = 48'({$urandom, $urandom});
    else wall = wall + 48'($urandom_range(40));
    d = ($urandom_range(9) == 0) ? $urandom : $urandom_range(60);
    x = $urandom;
    a = ($urandom_range(9) == 0) ? $urandom : $urandom_range(50);
    s = 4'($urandom);
    o = 1'($urandom);
    if (r < 35) send(oetb_pkg::MODE_START, wall, s, d, o, x);
    else if (r < 60) send(oetb_pkg::MODE_POLL, wall, s, x, o, d);
    else if (r < 72) send(oetb_pkg::MODE_FFWD, wall, s, x, o, a);
    else if (r < 80) send(oetb_pkg::MODE_STOP, wall, s, x, o, d);
    else if (r < 88) send(oetb_pkg::MODE_PAUSE, wall, s, x, o, d);
    else if (r < 96) send(oetb_pkg::MODE_RESUME, wall, s, x, o, d);
    else send(3'($urandom_range(6, 7)), 48'({$urandom, $urandom}), s, x, o, d);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed: acknowledge, zero period, extremes, pause/resume corners
    send(oetb_pkg::MODE_POLL, '0, '0, '0, 1'b0, '0);
    send(oetb_pkg::MODE_START, 48'd10, 4'd0, 32'd0, 1'b0, '0);
    send(oetb_pkg::MODE_START, 48'd10, 4'd15, 32'hFFFF_FFFF, 1'b1, '0);
    send(oetb_pkg::MODE_START, 48'd10, 4'd3, 32'd5, 1'b1, '0);
    send(oetb_pkg::MODE_START, 48'd10, 4'd4, 32'd5, 1'b1, '0);
    send(oetb_pkg::MODE_POLL, 48'd20, 4'd0, '0, 1'b0, '0);
    send(oetb_pkg::MODE_POLL, 48'd20, 4'd0, '0, 1'b0, '0);
    send(oetb_pkg::MODE_STOP, 48'd20, 4'd0, '0, 1'b0, '0);
    send(oetb_pkg::MODE_STOP, 48'd20, 4'd0, '0, 1'b0, '0);
    send(oetb_pkg::MODE_FFWD, 48'd20, 4'd0, '0, 1'b0, 32'hFFFF_FFFF);
    send(oetb_pkg::MODE_START, 48'hFFFF_FFFF_FFFF, 4'd7, 32'd3, 1'b0, '0);
    send(oetb_pkg::MODE_RESUME, 48'd30, 4'd0, '0, 1'b0, '0);
    send(oetb_pkg::MODE_PAUSE, 48'hFFFF_FFFF_FFFF, 4'd0, '0, 1'b0, '0);
    send(oetb_pkg::MODE_PAUSE, 48'd5, 4'd0, '0, 1'b0, '0);
    send(oetb_pkg::MODE_POLL, 48'd9, 4'd0, '0, 1'b0, '0);
    send(oetb_pkg::MODE_RESUME, 48'd0, 4'd0, '0, 1'b0, '0);
    send(3'd6, 48'hFFFF_FFFF_FFFF, 4'hF, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
    send(3'd7, 48'd1, 4'd1, 32'd1, 1'b0, 32'd1);
    send(oetb_pkg::MODE_FFWD, 48'd100, 4'd0, '0, 1'b0, 32'd100);
    send(oetb_pkg::MODE_POLL, 48'd200, 4'd0, '0, 1'b0, '0);
    // random phases: gapless, sparse, busy again, mixed
    for (int ph = 0; ph < 4; ph++) begin
      gap_pct = (ph == 1) ? 56 : (ph == 3) ? 9 : 0;
      repeat (110) random_item();
    end
    start <= 1'b0;
    while (pending_count > 0) @(posedge clk);
    repeat (2000) begin
      @(posedge clk);
      if (!busy) break;
    end
    repeat (20) @(posedge clk);
    $display("sent %0d items across four pacing phases, %0d timer expiries checked",
             items_sent, expiry_count);
    if (fail_count == 0 && pending_count == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end
endmodule
